@@ sv/bmaf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmaf_pkg
// Shared types and constants for the bitmap allocator find-free block.
// ----------------------------------------------------------------------------
package bmaf_pkg;

   // Bitmap word geometry
   localparam int WORD_BITS = 32;
   localparam int BIT_W     = $clog2(WORD_BITS);

   // Field widths
   localparam int CMD_W   = 3;
   localparam int IDX_W   = 10;
   localparam int COUNT_W = 11;

   // CSR port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic [COUNT_W-1:0] BIT_COUNT_RESET = COUNT_W'(1024);
   localparam logic               CSR_REG_BIT_COUNT = 1'b0;

   typedef logic [CMD_W-1:0]     cmd_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [COUNT_W-1:0]   count_type;
   typedef logic [WORD_BITS-1:0] word_type;

   // Command codes
   localparam cmd_type CMD_SET       = 3'd0;
   localparam cmd_type CMD_CLEAR     = 3'd1;
   localparam cmd_type CMD_TEST      = 3'd2;
   localparam cmd_type CMD_FIND      = 3'd3;
   localparam cmd_type CMD_CLEAR_ALL = 3'd4;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;    // latch a new transaction
      logic rd_word;   // read the word addressed by bit_index
      logic modify;    // set / clear / test on the read word
      logic find;      // scan words for a free bit
      logic clear;     // zero the word at the sweep pointer
      logic out_load;  // move the result into the output register
   } ctl_type;

   // Datapath to controller status
   typedef struct packed {
      logic hit;        // checked word holds a free valid bit
      logic scan_more;  // scan pointer not yet past the last valid word
      logic pend;       // a scan read is in flight
      logic scan_last;  // sweep pointer at the last word
   } sts_type;

   // Mask of the low n bits of a word
   function automatic word_type low_mask(input logic [BIT_W-1:0] n);
      word_type m;
      m = (word_type'(1) << n) - word_type'(1);
      return m;
   endfunction

endpackage

@@ sv/bmaf_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmaf_ifs
// Request and response channel interfaces (valid / ready handshake).
// ----------------------------------------------------------------------------
interface bmaf_req_if;
   logic              valid;
   logic              ready;
   bmaf_pkg::cmd_type command;
   bmaf_pkg::idx_type bit_index;

   modport source (output valid, output command, output bit_index, input ready);
   modport sink   (input valid, input command, input bit_index, output ready);
endinterface

interface bmaf_rsp_if;
   logic              valid;
   logic              ready;
   logic              ok;
   bmaf_pkg::idx_type found_index;

   modport source (output valid, output ok, output found_index, input ready);
   modport sink   (input valid, input ok, input found_index, output ready);
endinterface

@@ sv/bmaf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmaf_ctrl
// Sequencer: accepts a transaction, steps the datapath through the read,
// modify, scan or sweep phases and hands the result to the output register.
// ----------------------------------------------------------------------------
module bmaf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bmaf_pkg::cmd_type req_command,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  bmaf_pkg::sts_type sts,
   output bmaf_pkg::ctl_type ctl
);

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_RD    = 3'd2;
   localparam logic [2:0] ST_MOD   = 3'd3;
   localparam logic [2:0] ST_FIND  = 3'd4;
   localparam logic [2:0] ST_SWEEP = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign req_ready = (state_ff == ST_IDLE);

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         ST_INIT: begin
            ctl.clear = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               ctl.accept = 1'b1;
               unique case (req_command)
                  bmaf_pkg::CMD_SET,
                  bmaf_pkg::CMD_CLEAR,
                  bmaf_pkg::CMD_TEST:      state_in = ST_RD;
                  bmaf_pkg::CMD_FIND:      state_in = ST_FIND;
                  bmaf_pkg::CMD_CLEAR_ALL: state_in = ST_SWEEP;
                  default:                 state_in = ST_OUT;
               endcase
            end
         end
         ST_RD: begin
            ctl.rd_word = 1'b1;
            state_in    = ST_MOD;
         end
         ST_MOD: begin
            ctl.modify = 1'b1;
            state_in   = ST_OUT;
         end
         ST_FIND: begin
            ctl.find = 1'b1;
            if (sts.hit || (!sts.scan_more && !sts.pend)) begin
               state_in = ST_OUT;
            end
         end
         ST_SWEEP: begin
            ctl.clear = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               ctl.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output valid: set on load, dropped when taken
   always_comb begin
      priority if (ctl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ sv/bmaf_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmaf_dpath
// Bitmap word memory, hint and scan pointer, bit update logic, free-bit
// search on one word per cycle, and result / output registers.
// ----------------------------------------------------------------------------
module bmaf_dpath #(
   parameter int MAX_BITS = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  bmaf_pkg::ctl_type   ctl,
   output bmaf_pkg::sts_type   sts,
   input  bmaf_pkg::cmd_type   req_command,
   input  bmaf_pkg::idx_type   req_bit_index,
   input  bmaf_pkg::count_type bit_count,
   output logic                rsp_ok,
   output bmaf_pkg::idx_type   rsp_found_index
);

   localparam int WB     = bmaf_pkg::WORD_BITS;
   localparam int BW     = bmaf_pkg::BIT_W;
   localparam int IW     = bmaf_pkg::IDX_W;
   localparam int NWORDS = MAX_BITS / WB;
   localparam int WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int MB_W   = $clog2(MAX_BITS + 1);
   localparam int CNT_W  = (MB_W > bmaf_pkg::COUNT_W) ? MB_W : bmaf_pkg::COUNT_W;

   typedef logic [WAW-1:0] waddr_type;
   typedef logic [WAW:0]   wcount_type;
   typedef logic [CNT_W-1:0] cnt_type;

   // Bitmap storage
   bmaf_pkg::word_type mem [NWORDS];

   bmaf_pkg::cmd_type  cmd_ff;
   bmaf_pkg::idx_type  idx_ff;
   waddr_type          hint_ff, hint_in;
   wcount_type         scan_ff, scan_in;
   waddr_type          chk_word_ff;
   logic               pend_ff;
   bmaf_pkg::word_type rdata_ff;
   logic               res_ok_ff, res_ok_in;
   bmaf_pkg::idx_type  res_idx_ff, res_idx_in;
   logic               out_ok_ff;
   bmaf_pkg::idx_type  out_idx_ff;

   cnt_type            eff_cnt;
   cnt_type            cnt_ext;
   cnt_type            full_words;
   wcount_type         len_words;
   logic               in_range;
   waddr_type          idx_word;
   bmaf_pkg::word_type bit_mask;
   bmaf_pkg::word_type valid_mask;
   bmaf_pkg::word_type free_bits;
   logic [BW-1:0]      free_pos;
   logic               scan_more;
   logic               hit;
   logic               rd_en;
   waddr_type          rd_addr;
   logic               wr_en;
   waddr_type          wr_addr;
   bmaf_pkg::word_type wr_data;
   logic               is_set;
   logic               is_clear;

   // Lowest set bit of a word
   function automatic logic [BW-1:0] first_one(input bmaf_pkg::word_type w);
      logic [BW-1:0] pos;
      pos = '0;
      for (int i = WB - 1; i >= 0; i--) begin
         if (w[i]) begin
            pos = BW'(i);
         end
      end
      return pos;
   endfunction

   // Effective count and number of valid words
   assign cnt_ext    = CNT_W'(bit_count);
   assign eff_cnt    = (cnt_ext > CNT_W'(MAX_BITS)) ? CNT_W'(MAX_BITS) : cnt_ext;
   assign full_words = eff_cnt >> BW;
   assign len_words  = (WAW + 1)'((eff_cnt + CNT_W'(WB - 1)) >> BW);

   // Single-bit access decode
   assign in_range = CNT_W'(idx_ff) < eff_cnt;
   assign idx_word = WAW'(idx_ff[IW-1:BW]);
   assign bit_mask = bmaf_pkg::word_type'(1) << idx_ff[BW-1:0];
   assign is_set   = (cmd_ff == bmaf_pkg::CMD_SET);
   assign is_clear = (cmd_ff == bmaf_pkg::CMD_CLEAR);

   // Scan check on the word read last cycle
   assign valid_mask = (CNT_W'(chk_word_ff) < full_words) ? '1
                                                          : bmaf_pkg::low_mask(eff_cnt[BW-1:0]);
   assign free_bits  = ~rdata_ff & valid_mask;
   assign free_pos   = first_one(free_bits);
   assign hit        = pend_ff && (free_bits != '0);
   assign scan_more  = scan_ff < len_words;

   assign sts.hit       = hit;
   assign sts.scan_more = scan_more;
   assign sts.pend      = pend_ff;
   assign sts.scan_last = (scan_ff == wcount_type'(NWORDS - 1));

   // Memory port control
   assign rd_en   = ctl.rd_word || (ctl.find && scan_more);
   assign rd_addr = ctl.find ? scan_ff[WAW-1:0] : idx_word;
   assign wr_en   = ctl.clear || (ctl.modify && in_range && (is_set || is_clear));
   assign wr_addr = ctl.clear ? scan_ff[WAW-1:0] : idx_word;
   assign wr_data = ctl.clear ? '0 : (is_set ? (rdata_ff | bit_mask) : (rdata_ff & ~bit_mask));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Hint and scan / sweep pointer
   always_comb begin
      hint_in = hint_ff;
      scan_in = scan_ff;
      priority if (ctl.accept) begin
         if (req_command == bmaf_pkg::CMD_CLEAR_ALL) begin
            hint_in = '0;
            scan_in = '0;
         end else begin
            scan_in = wcount_type'(hint_ff);
         end
      end else if (ctl.clear) begin
         scan_in = scan_ff + wcount_type'(1);
      end else if (ctl.find) begin
         if (scan_more) begin
            scan_in = scan_ff + wcount_type'(1);
         end
         if (hit) begin
            hint_in = chk_word_ff;
         end
      end else if (ctl.modify) begin
         if (is_clear && in_range) begin
            hint_in = '0;
         end
      end else begin
         hint_in = hint_ff;
      end
   end

   // Pending result
   always_comb begin
      res_ok_in  = res_ok_ff;
      res_idx_in = res_idx_ff;
      priority if (ctl.accept) begin
         res_ok_in  = (req_command == bmaf_pkg::CMD_CLEAR_ALL);
         res_idx_in = '0;
      end else if (ctl.modify) begin
         res_ok_in = in_range && (is_set || is_clear || ((rdata_ff & bit_mask) != '0));
      end else if (ctl.find && hit) begin
         res_ok_in  = 1'b1;
         res_idx_in = IW'({chk_word_ff, free_pos});
      end else begin
         res_ok_in = res_ok_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hint_ff <= '0;
         scan_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         hint_ff <= hint_in;
         scan_ff <= scan_in;
         pend_ff <= ctl.find && scan_more;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff <= req_command;
         idx_ff <= req_bit_index;
      end
      chk_word_ff <= scan_ff[WAW-1:0];
      res_ok_ff   <= res_ok_in;
      res_idx_ff  <= res_idx_in;
      if (ctl.out_load) begin
         out_ok_ff  <= res_ok_ff;
         out_idx_ff <= res_idx_ff;
      end
   end

   assign rsp_ok          = out_ok_ff;
   assign rsp_found_index = out_idx_ff;

endmodule

@@ sv/bitmap_allocator_find_free_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_allocator_find_free_unit
// Bitmap allocator with a word hint: set, clear, test, find first free, clear all.
// Set / clear / test read the addressed word and then modify it, an undefined
// command goes straight to the output, find reads one word per cycle from the hint
// and clear all zeroes one word per cycle. One transaction at a time: the next
// request is taken the cycle after the result loads. Synchronous reset, then a
// sweep zeroes all NWORDS (32 here) words of the memory.
// ----------------------------------------------------------------------------
module bitmap_allocator_find_free_unit #(
   parameter int MAX_BITS = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   bmaf_req_if.sink                    req_ch,
   bmaf_rsp_if.source                  rsp_ch,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [bmaf_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [bmaf_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [bmaf_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);

   bmaf_pkg::count_type bit_count_ff;
   bmaf_pkg::ctl_type   ctl;
   bmaf_pkg::sts_type   sts;
   logic                csr_wr;
   logic                csr_sel_count;

   // CSR access
   assign csr_pready    = 1'b1;
   assign csr_sel_count = (csr_paddr[2] == bmaf_pkg::CSR_REG_BIT_COUNT);
   assign csr_wr        = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata    = csr_sel_count ? bmaf_pkg::CSR_DW'(bit_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff <= bmaf_pkg::BIT_COUNT_RESET;
      end else if (csr_wr && csr_sel_count) begin
         bit_count_ff <= csr_pwdata[bmaf_pkg::COUNT_W-1:0];
      end
   end

   // Sequencer
   bmaf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_command (req_ch.command),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .sts         (sts),
      .ctl         (ctl)
   );

   // Datapath
   bmaf_dpath #(
      .MAX_BITS (MAX_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .sts             (sts),
      .req_command     (req_ch.command),
      .req_bit_index   (req_ch.bit_index),
      .bit_count       (bit_count_ff),
      .rsp_ok          (rsp_ch.ok),
      .rsp_found_index (rsp_ch.found_index)
   );

endmodule
